// ----- rtl/nhb_pkg.sv -----
package nhb_pkg;

  localparam int MAX_BINS_DEF   = 16;
  localparam int MAX_DIMS_DEF   = 3;
  localparam int COUNT_BITS_DEF = 32;

  localparam int COORD_W = 32;
  localparam int BIN_W   = 12;
  localparam int OUT_CNT_W = 32;
  localparam int REG_W   = 32;
  localparam int IDX_W   = 3;

  // dividend width and step count of the shared divider
  localparam int DIV_W   = 37;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [IDX_W-1:0] REG_BINS    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DIMS    = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOWER_0 = 3'd2;
  localparam logic [IDX_W-1:0] REG_UPPER_0 = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOWER_1 = 3'd4;
  localparam logic [IDX_W-1:0] REG_UPPER_1 = 3'd5;
  localparam logic [IDX_W-1:0] REG_LOWER_2 = 3'd6;
  localparam logic [IDX_W-1:0] REG_UPPER_2 = 3'd7;

  typedef struct packed {
    logic               command;
    logic signed [31:0] coord_0;
    logic signed [31:0] coord_1;
    logic signed [31:0] coord_2;
    logic [11:0]        read_bin;
  } in_item_t;

  typedef struct packed {
    logic [11:0] bin_number;
    logic [31:0] bin_count;
    logic        clamped;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic [1:0] dim;
    logic       sub_start;
    logic       div_step;
    logic       accum;
    logic       mem_rd;
    logic       mem_wr;
    logic       out_load;
  } nhb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_read;
    logic [1:0] ndims;
  } nhb_sts_t;

endpackage

// ----- rtl/nhb_ram.sv -----
module nhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/nhb_ctrl.sv -----
module nhb_ctrl
  import nhb_pkg::*;
#(
  parameter int DEPTH = MAX_BINS_DEF * MAX_BINS_DEF * MAX_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     clearing,
  output logic [$clog2(DEPTH)-1:0] clr_addr,
  output nhb_cmd_t                 cmd,
  input  nhb_sts_t                 sts
);

  localparam int AW = $clog2(DEPTH);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SUB   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    dim_r, dim_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt  = state_r;
    dim_nxt    = dim_r;
    cnt_nxt    = cnt_r;
    clr_nxt    = clr_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    cmd.dim    = dim_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          dim_nxt   = 2'd0;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        if (sts.is_read) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_WAIT;
        end else begin
          cmd.sub_start = 1'b1;
          cnt_nxt       = 6'd0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          cmd.accum = 1'b1;
          if ({1'b0, dim_r} + 3'd1 >= {1'b0, sts.ndims}) begin
            state_nxt = S_RD;
          end else begin
            dim_nxt   = dim_r + 2'd1;
            state_nxt = S_SUB;
          end
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (!ovalid_r || !out_stall) begin
          cmd.mem_wr   = !sts.is_read;
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      dim_r    <= '0;
      cnt_r    <= '0;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dim_r    <= dim_nxt;
      cnt_r    <= cnt_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign clearing  = (state_r == S_CLEAR);
  assign clr_addr  = clr_r;

endmodule

// ----- rtl/nhb_dp.sv -----
module nhb_dp
  import nhb_pkg::*;
#(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  in_item_t         in_data,
  input  nhb_cmd_t         cmd,
  input  logic             clearing,
  input  logic [$clog2(MAX_BINS*MAX_BINS*MAX_BINS)-1:0] clr_addr,
  output nhb_sts_t         sts,
  output out_item_t        out_data
);

  localparam int DEPTH = MAX_BINS * MAX_BINS * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NBW   = $clog2(MAX_BINS + 1);
  localparam int SW    = $clog2(MAX_BINS);
  localparam int XW    = AW + NBW + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [4:0] bins_r;
  logic [1:0] dims_r;
  logic signed [31:0] lower_r [3];
  logic signed [31:0] upper_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= 5'd16;
      dims_r <= 2'd3;
      for (int d = 0; d < 3; d++) begin
        lower_r[d] <= '0;
        upper_r[d] <= 32'sd65536;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BINS:    bins_r     <= cfg_data[4:0];
        REG_DIMS:    dims_r     <= cfg_data[1:0];
        REG_LOWER_0: lower_r[0] <= cfg_data;
        REG_UPPER_0: upper_r[0] <= cfg_data;
        REG_LOWER_1: lower_r[1] <= cfg_data;
        REG_UPPER_1: upper_r[1] <= cfg_data;
        REG_LOWER_2: lower_r[2] <= cfg_data;
        REG_UPPER_2: upper_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NBW-1:0] nb;
  logic [1:0]     nd;
  always_comb begin
    if (bins_r == 5'd0) nb = NBW'(1);
    else if (32'(bins_r) > MAX_BINS) nb = NBW'(MAX_BINS);
    else nb = NBW'(bins_r);
    if (dims_r == 2'd0) nd = 2'd1;
    else if (32'(dims_r) > MAX_DIMS) nd = 2'(MAX_DIMS);
    else nd = dims_r;
  end

  in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end
  assign sts.is_read = item_r.command == CMD_READ;
  assign sts.ndims   = nd;

  logic signed [31:0] v, lo, hi;
  always_comb begin
    case (cmd.dim)
      2'd1: begin v = item_r.coord_1; lo = lower_r[1]; hi = upper_r[1]; end
      2'd2: begin v = item_r.coord_2; lo = lower_r[2]; hi = upper_r[2]; end
      default: begin v = item_r.coord_0; lo = lower_r[0]; hi = upper_r[0]; end
    endcase
  end

  // restoring divider: quotient of (nb-1)*diff by span, one step per dividend bit
  logic [32:0] diff, span;
  logic [DIV_W-1:0] prod;
  assign diff = 33'($signed({v[31], v}) - $signed({lo[31], lo}));
  assign span = 33'($signed({hi[31], hi}) - $signed({lo[31], lo}));
  assign prod = DIV_W'(diff) * DIV_W'(nb - NBW'(1));

  logic [DIV_W-1:0] dvd_r;
  logic [32:0] span_r;
  logic [32:0] rem_r;
  logic [1:0]  mode_r;
  logic        clamp_r;
  logic [33:0] trial;
  assign trial = {rem_r, dvd_r[DIV_W-1]} - {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (cmd.load) clamp_r <= 1'b0;
    if (cmd.sub_start) begin
      dvd_r  <= prod;
      span_r <= span;
      rem_r  <= '0;
      if (hi <= lo || v < lo) begin
        mode_r <= 2'd1; clamp_r <= 1'b1;
      end else if (v > hi) begin
        mode_r <= 2'd2; clamp_r <= 1'b1;
      end else begin
        mode_r <= 2'd0;
      end
    end else if (cmd.div_step) begin
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        dvd_r <= {dvd_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], dvd_r[DIV_W-1]};
        dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  logic [SW-1:0] subidx;
  always_comb begin
    case (mode_r)
      2'd1: subidx = '0;
      2'd2: subidx = SW'(nb - NBW'(1));
      default: subidx = SW'({dvd_r[DIV_W-2:0], ~trial[33]});
    endcase
  end

  logic [AW-1:0] idx_r;
  logic [XW-1:0] idx_x;
  assign idx_x = XW'(idx_r) * XW'(nb) + XW'(subidx);
  always_ff @(posedge clk) begin
    if (cmd.load) idx_r <= '0;
    else if (cmd.accum) idx_r <= AW'(idx_x);
  end

  logic [AW-1:0] addr;
  logic          oob;
  assign oob  = sts.is_read && (32'(item_r.read_bin) >= DEPTH);
  assign addr = sts.is_read ? AW'(item_r.read_bin) : idx_r;

  logic [COUNT_BITS-1:0] rdata, inc;
  logic                  oob_r;
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) oob_r <= oob;
  end
  assign inc = (rdata == CMAX) ? rdata : rdata + 1'b1;

  nhb_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .wr_en  (clearing || cmd.mem_wr),
    .wr_addr(clearing ? clr_addr : idx_r),
    .wr_data(clearing ? {COUNT_BITS{1'b0}} : inc),
    .rd_addr(addr),
    .rd_data(rdata)
  );

  logic [COUNT_BITS-1:0] res_cnt;
  assign res_cnt = sts.is_read ? (oob_r ? {COUNT_BITS{1'b0}} : rdata) : inc;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.bin_number <= sts.is_read ? item_r.read_bin : BIN_W'(idx_r);
      out_data.bin_count  <= OUT_CNT_W'(res_cnt);
      out_data.clamped    <= sts.is_read ? 1'b0 : clamp_r;
    end
  end

endmodule

// ----- rtl/ndim_histogram_binner.sv -----
// The block takes one item at a time: an add loads the item, then per used dimension
//   runs a subtract state and the 37-step shared restoring divider, then reads the
//   count memory, waits and writes back the incremented count as its result; a read
//   skips the divider and returns the addressed count; a stalled result holds the
//   block until its output register is free
// reset: synchronous active-low rst_n; after reset a clearing pass over all
//   MAX_BINS^3 entries zeroes the count memory before the first item is taken
module ndim_histogram_binner
  import nhb_pkg::*;
#(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_BINS * MAX_BINS * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);

  nhb_cmd_t      cmd;
  nhb_sts_t      sts;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  nhb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .clearing (clearing),
    .clr_addr (clr_addr),
    .cmd      (cmd),
    .sts      (sts)
  );

  nhb_dp #(.MAX_BINS(MAX_BINS), .MAX_DIMS(MAX_DIMS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .clearing (clearing),
    .clr_addr (clr_addr),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import nhb_pkg::*;

  localparam int MEM_DEPTH = MAX_BINS_DEF * MAX_BINS_DEF * MAX_BINS_DEF;
  localparam longint LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  ndim_histogram_binner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] counts [MEM_DEPTH];
  logic [4:0] bins_reg;
  logic [1:0] dims_reg;
  logic signed [31:0] lo_reg [3];
  logic signed [31:0] hi_reg [3];

  out_item_t expected_q [$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_clamped = 0;
  int n_reads = 0;
  longint cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;

  task automatic report_mismatch(input string what, input out_item_t got, input out_item_t exp);
    errors++;
    $display("mismatch %s: got bin %0d cnt %0d clamp %0d, exp bin %0d cnt %0d clamp %0d",
             what, got.bin_number, got.bin_count, got.clamped,
             exp.bin_number, exp.bin_count, exp.clamped);
  endtask

  function automatic logic [4:0] sub_bin(input logic signed [31:0] v, input int d,
                                         input logic [4:0] nb, inout logic clamp);
    logic signed [33:0] diff;
    logic signed [33:0] span;
    logic [39:0] prod;
    if (hi_reg[d] <= lo_reg[d] || v < lo_reg[d]) begin
      clamp = 1'b1;
      return 5'd0;
    end
    if (v > hi_reg[d]) begin
      clamp = 1'b1;
      return nb - 5'd1;
    end
    diff = 34'(v) - 34'(lo_reg[d]);
    span = 34'(hi_reg[d]) - 34'(lo_reg[d]);
    prod = 40'(nb - 5'd1) * 40'(diff);
    return 5'(prod / 40'(span));
  endfunction

  function automatic out_item_t histogram_step(input in_item_t it);
    out_item_t r;
    logic [4:0] nb;
    int nd;
    int idx;
    logic clamp;
    r = '0;
    if (it.command == CMD_READ) begin
      r.bin_number = it.read_bin;
      r.bin_count = (int'(it.read_bin) < MEM_DEPTH) ? counts[it.read_bin] : 32'd0;
      return r;
    end
    nb = bins_reg;
    if (nb < 5'd1) nb = 5'd1;
    if (nb > 5'(MAX_BINS_DEF)) nb = 5'(MAX_BINS_DEF);
    nd = int'(dims_reg);
    if (nd < 1) nd = 1;
    if (nd > MAX_DIMS_DEF) nd = MAX_DIMS_DEF;
    idx = 0;
    clamp = 1'b0;
    for (int d = 0; d < nd; d++)
      idx = idx * nb + sub_bin(d == 0 ? it.coord_0 : d == 1 ? it.coord_1 : it.coord_2,
                               d, nb, clamp);
    if (idx >= MEM_DEPTH) idx = MEM_DEPTH - 1;
    if (counts[idx] != 32'hFFFF_FFFF) counts[idx] = counts[idx] + 1;
    r.bin_number = 12'(idx);
    r.bin_count = counts[idx];
    r.clamped = clamp;
    return r;
  endfunction

  // output side
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_recv++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected", out_data, '0);
        end else begin
          if (out_data.bin_number !== expected_q[0].bin_number)
            report_mismatch("bin_number", out_data, expected_q[0]);
          else if (out_data.bin_count !== expected_q[0].bin_count)
            report_mismatch("bin_count", out_data, expected_q[0]);
          else if (out_data.clamped !== expected_q[0].clamped)
            report_mismatch("clamped", out_data, expected_q[0]);
          void'(expected_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BINS: bins_reg = val[4:0];
      REG_DIMS: dims_reg = val[1:0];
      default: begin
        if (idx[0] == 1'b0) lo_reg[(idx - 2) >> 1] = val;
        else hi_reg[(idx - 2) >> 1] = val;
      end
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic send(input in_item_t it, input logic has_exp = 1'b0,
                      input out_item_t exp = '0);
    out_item_t p;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = histogram_step(it);
    if (has_exp && p !== exp) report_mismatch("directed row", p, exp);
    expected_q.push_back(p);
    n_sent++;
    if (it.command == CMD_READ) n_reads++;
    if (p.clamped) n_clamped++;
  endtask

  function automatic logic [31:0] rand_coord(input int d);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = lo_reg[d];
    hi = hi_reg[d];
    case ($urandom_range(9))
      0: return $urandom();
      1: return lo;
      2: return hi;
      3: return lo - 1;
      4: return hi + 1;
      default: begin
        if ($signed(hi) > $signed(lo))
          return lo + 32'(64'($urandom()) % (64'(hi - lo) + 64'd1));
        return $urandom();
      end
    endcase
  endfunction

  task automatic random_items(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.command = ($urandom_range(4) == 0) ? CMD_READ : CMD_ADD;
      it.coord_0 = rand_coord(0);
      it.coord_1 = rand_coord(1);
      it.coord_2 = rand_coord(2);
      it.read_bin = ($urandom_range(3) == 0) ? 12'($urandom()) : expected_q.size() > 0
                    ? expected_q[$].bin_number : 12'($urandom());
      send(it);
    end
  endtask

  typedef struct {
    in_item_t it;
    logic has_exp;
    out_item_t exp;
  } row_t;

  row_t rows [$];

  task automatic add_row(input logic cmd, input logic [31:0] c0, input logic [31:0] c1,
                         input logic [31:0] c2, input logic [11:0] rb,
                         input logic has_exp, input logic [11:0] eb,
                         input logic [31:0] ec, input logic ecl);
    row_t r;
    r.it = '{cmd, c0, c1, c2, rb};
    r.has_exp = has_exp;
    r.exp = '{eb, ec, ecl};
    rows.push_back(r);
  endtask

  initial begin
    foreach (counts[i]) counts[i] = '0;
    bins_reg = 5'd16;
    dims_reg = 2'd3;
    for (int d = 0; d < 3; d++) begin
      lo_reg[d] = 0;
      hi_reg[d] = 65536;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration
    add_row(CMD_READ, 0, 0, 0, 12'd0, 1, 12'd0, 0, 0);
    add_row(CMD_READ, 0, 0, 0, 12'hFFF, 1, 12'hFFF, 0, 0);
    add_row(CMD_ADD, 0, 0, 0, 0, 1, 12'd0, 1, 0);
    add_row(CMD_ADD, 0, 0, 0, 12'hFFF, 1, 12'd0, 2, 0);
    add_row(CMD_ADD, 65536, 65536, 65536, 0, 1, 12'hFFF, 1, 0);
    add_row(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 12'd0, 3, 1);
    add_row(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 12'hFFF, 2, 1);
    add_row(CMD_ADD, 32'hFFFF_FFFF, 65537, 0, 0, 1, 12'h0F0, 1, 1);
    add_row(CMD_ADD, 32768, 16384, 49152, 0, 0, 0, 0, 0);
    add_row(CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 12345, 0, 0, 0, 0, 0);
    add_row(CMD_READ, 0, 0, 0, 12'hFFF, 1, 12'hFFF, 2, 0);
    add_row(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'h0F0, 1, 12'h0F0, 1, 0);
    foreach (rows[i]) send(rows[i].it, rows[i].has_exp, rows[i].exp);
    drain();

    // single bin, one dimension, out-of-range register values
    write_reg(REG_BINS, 32'd1);
    write_reg(REG_DIMS, 32'd1);
    send('{CMD_ADD, 32'h7FFF_FFFF, 0, 0, 0}, 1, '{12'd0, 32'd4, 1'b1});
    send('{CMD_ADD, 100, 0, 0, 0}, 1, '{12'd0, 32'd5, 1'b0});
    write_reg(REG_BINS, 32'd0);
    write_reg(REG_DIMS, 32'd0);
    send('{CMD_ADD, 100, 0, 0, 0}, 1, '{12'd0, 32'd6, 1'b0});
    write_reg(REG_BINS, 32'h1F);
    write_reg(REG_DIMS, 32'd2);
    write_reg(REG_UPPER_0, 32'h8000_0000);
    send('{CMD_ADD, 5, 65536, 0, 0}, 1, '{12'd15, 32'd1, 1'b1});
    drain();

    // random phases with varied configuration and idling
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 80; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 80; end
        3: begin send_idle = 36; recv_stall = 36; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      write_reg(REG_BINS, (ph == 0) ? 32'd16 : (ph == 1) ? 32'd2 : $urandom_range(31));
      write_reg(REG_DIMS, (ph == 2) ? 32'd3 : $urandom_range(3));
      for (int r = REG_LOWER_0; r <= REG_UPPER_2; r += 2) begin
        logic [31:0] lo;
        logic [31:0] w;
        case ($urandom_range(4))
          0: begin lo = 32'h8000_0000; w = 32'hFFFF_FFFF; end
          1: begin lo = $urandom(); w = $urandom(); end
          2: begin lo = $urandom(); w = 32'hFFFF_FFFF - $urandom_range(3); end
          default: begin lo = $urandom_range(1 << 20) - (1 << 19); w = $urandom_range(1 << 20); end
        endcase
        write_reg(IDX_W'(r), lo);
        write_reg(IDX_W'(r + 1), ($signed(lo + w) < $signed(lo) && ph != 3) ? 32'h7FFF_FFFF
                                 : lo + w);
      end
      random_items(125);
      drain();
    end

    $display("%0d transfers sent, %0d received, %0d reads, %0d clamped adds",
             n_sent, n_recv, n_reads, n_clamped);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
